### rtl/core/ddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared widths, register codes, cordic types and the arctangent table for
// the differential drive odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

    // trig and position format
    localparam int TRIG_STAGES        = 16;
    localparam int MAX_STAGES         = 24;
    localparam int POSITION_FRAC_BITS = 16;

    // field widths
    localparam int COUNT_W    = 32;
    localparam int POS_W      = 32;
    localparam int ANGLE_W    = 32;
    localparam int DPT_W      = 24;
    localparam int APT_W      = 28;
    localparam int CFG_DATA_W = 28;
    localparam int CFG_IDX_W  = 1;

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_TICK  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_PER_TICK = CFG_IDX_W'(1);
    localparam logic [DPT_W-1:0]     DPT_RESET          = DPT_W'(34953);
    localparam logic [APT_W-1:0]     APT_RESET          = APT_W'(17801007);

    // cordic vector, Q2.30
    localparam int CV_W      = 32;
    localparam int TRIG_FRAC = 30;
    localparam int STAGE_W   = $clog2(TRIG_STAGES);
    localparam logic signed [CV_W-1:0] CORDIC_GAIN = CV_W'(652032875);

    // shared multiplier, split into two half-width passes
    localparam int MUL_W      = 34;
    localparam int MUL_HALF   = MUL_W / 2;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int DIST_W     = 34;
    localparam int DIST_SHIFT = 25 - POSITION_FRAC_BITS;
    localparam int INC_W      = PROD_W - TRIG_FRAC;

    typedef struct packed {
        logic [1:0]                quad;
        logic signed [CV_W-1:0]    x;
        logic signed [CV_W-1:0]    y;
        logic signed [ANGLE_W-1:0] z;
    } t_cvec;

    // atan(2^-k) in binary angle units of a full turn 2^32
    function automatic logic signed [ANGLE_W-1:0] atan_of(input int unsigned k);
        logic signed [ANGLE_W-1:0] v;
        unique case (k)
            0:       v = ANGLE_W'(32'h2000_0000);
            1:       v = ANGLE_W'(32'h12E4_051E);
            2:       v = ANGLE_W'(32'h09FB_385B);
            3:       v = ANGLE_W'(32'h0511_11D4);
            4:       v = ANGLE_W'(32'h028B_0D43);
            5:       v = ANGLE_W'(32'h0145_D7E1);
            6:       v = ANGLE_W'(32'h00A2_F61E);
            7:       v = ANGLE_W'(32'h0051_7C55);
            8:       v = ANGLE_W'(32'h0028_BE53);
            9:       v = ANGLE_W'(32'h0014_5F2F);
            10:      v = ANGLE_W'(32'h000A_2F98);
            11:      v = ANGLE_W'(32'h0005_17CC);
            12:      v = ANGLE_W'(32'h0002_8BE6);
            13:      v = ANGLE_W'(32'h0001_45F3);
            14:      v = ANGLE_W'(32'h0000_A2F9);
            15:      v = ANGLE_W'(32'h0000_517C);
            16:      v = ANGLE_W'(32'h0000_28BE);
            17:      v = ANGLE_W'(32'h0000_145F);
            18:      v = ANGLE_W'(32'h0000_0A2F);
            19:      v = ANGLE_W'(32'h0000_0517);
            20:      v = ANGLE_W'(32'h0000_028B);
            21:      v = ANGLE_W'(32'h0000_0145);
            22:      v = ANGLE_W'(32'h0000_00A2);
            23:      v = ANGLE_W'(32'h0000_0051);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/ddo_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_mul
// Signed 34 x 34 multiplier built from two half-width passes with a
// registered accumulator. Operands must hold from start until done.
// ----------------------------------------------------------------------------
module ddo_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [ddo_pkg::MUL_W-1:0]   i_a,
    input  logic signed [ddo_pkg::MUL_W-1:0]   i_b,
    output logic                               o_done,
    output logic signed [ddo_pkg::PROD_W-1:0]  o_prod
);
    import ddo_pkg::*;

    localparam int LO_W = MUL_HALF + 1;
    localparam int HI_W = MUL_W - MUL_HALF;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_LO,
        MS_HI
    } t_mstate;

    t_mstate r_state;
    logic    r_done;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [LO_W-1:0]       lo_op;
    logic signed [HI_W-1:0]       hi_op;
    logic signed [MUL_W+LO_W-1:0] p_lo;
    logic signed [MUL_W+HI_W-1:0] p_hi;

    always_comb begin
        lo_op = $signed({1'b0, i_b[MUL_HALF-1:0]});
        hi_op = $signed(i_b[MUL_W-1:MUL_HALF]);
        p_lo  = i_a * lo_op;
        p_hi  = i_a * hi_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == MS_HI);
            unique case (r_state)
                MS_IDLE: begin
                    if (i_start) begin
                        r_state <= MS_LO;
                    end
                end
                MS_LO: begin
                    r_prod  <= PROD_W'(p_lo);
                    r_state <= MS_HI;
                end
                MS_HI: begin
                    // upper half of b carries the sign
                    r_prod  <= r_prod + (PROD_W'(p_hi) <<< MUL_HALF);
                    r_state <= MS_IDLE;
                end
                default: r_state <= MS_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

### rtl/core/ddo_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic_cell
// One rotation-mode cordic micro-rotation with its output register.
// ----------------------------------------------------------------------------
module ddo_cordic_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  ddo_pkg::t_cvec                      i_vec,
    input  logic [ddo_pkg::STAGE_W-1:0]         i_shift,
    input  logic signed [ddo_pkg::ANGLE_W-1:0]  i_atan,
    output logic                                o_valid,
    output ddo_pkg::t_cvec                      o_vec
);
    import ddo_pkg::*;

    logic   r_valid;
    t_cvec  r_vec;
    t_cvec  n_vec;
    logic signed [CV_W-1:0] xs;
    logic signed [CV_W-1:0] ys;

    always_comb begin
        // arithmetic shift rounds toward minus infinity
        xs         = i_vec.x >>> i_shift;
        ys         = i_vec.y >>> i_shift;
        n_vec.quad = i_vec.quad;
        if (!i_vec.z[ANGLE_W-1]) begin
            n_vec.x = i_vec.x - ys;
            n_vec.y = i_vec.y + xs;
            n_vec.z = i_vec.z - i_atan;
        end else begin
            n_vec.x = i_vec.x + ys;
            n_vec.y = i_vec.y - xs;
            n_vec.z = i_vec.z + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

### rtl/core/ddo_cordic_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_cordic_chain
// Row of cordic cells giving cos and sin (Q2.30) of a 32-bit binary angle,
// with quadrant fold in front and unfold behind.
// ----------------------------------------------------------------------------
module ddo_cordic_chain (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [ddo_pkg::ANGLE_W-1:0]         i_angle,
    output logic                                o_valid,
    output logic signed [ddo_pkg::CV_W-1:0]     o_cos,
    output logic signed [ddo_pkg::CV_W-1:0]     o_sin
);
    import ddo_pkg::*;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    t_cvec w_vec   [TRIG_STAGES+1];
    logic  w_valid [TRIG_STAGES+1];
    t_cvec last_vec;

    always_comb begin
        w_vec[0].quad = i_angle[ANGLE_W-1 -: 2];
        w_vec[0].x    = CORDIC_GAIN;
        w_vec[0].y    = '0;
        w_vec[0].z    = $signed({2'b00, i_angle[ANGLE_W-3:0]});
        w_valid[0]    = i_start;
    end

    for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_cell
        ddo_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_vec   (w_vec[k]),
            .i_shift (STAGE_W'(k)),
            .i_atan  (atan_of(k)),
            .o_valid (w_valid[k+1]),
            .o_vec   (w_vec[k+1])
        );
    end

    assign last_vec = w_vec[TRIG_STAGES];
    assign o_valid  = w_valid[TRIG_STAGES];

    always_comb begin
        case (last_vec.quad)
            QUAD_0: begin
                o_cos = last_vec.x;
                o_sin = last_vec.y;
            end
            QUAD_1: begin
                o_cos = -last_vec.y;
                o_sin = last_vec.x;
            end
            QUAD_2: begin
                o_cos = -last_vec.x;
                o_sin = -last_vec.y;
            end
            default: begin
                o_cos = last_vec.y;
                o_sin = -last_vec.x;
            end
        endcase
    end

endmodule

### rtl/core/differential_drive_odometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoned pose from absolute wheel encoder counts, midpoint heading,
// cordic trig, saturating Q16.16 position and wrapping binary-angle heading.
// ----------------------------------------------------------------------------
//  channel   | handshake                      | payload
//  ----------+--------------------------------+----------------------------------
//  counts in | i_count_valid / o_count_ready  | i_left_count, i_right_count
//  pose out  | o_pose_valid  / i_pose_ready   | o_pose_x, o_pose_y,
//            |                                | o_pose_heading, o_pose_updated
//  config    | i_cfg_we (no wait)             | i_cfg_index, i_cfg_data
//
//  an updating beat makes four passes through the shared two-step
//  multiplier and one trip down the cordic cell row. the first beat after
//  reset only latches counts. one beat is worked at a time; the result sits
//  in an output register so the next beat is taken while it waits.
//  synchronous active-low reset clears the pose, the first-beat flag and
//  both registers to their defaults.
// ----------------------------------------------------------------------------
module differential_drive_odometry (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_count_valid,
    output logic                                 o_count_ready,
    input  logic signed [ddo_pkg::COUNT_W-1:0]   i_left_count,
    input  logic signed [ddo_pkg::COUNT_W-1:0]   i_right_count,
    output logic                                 o_pose_valid,
    input  logic                                 i_pose_ready,
    output logic signed [ddo_pkg::POS_W-1:0]     o_pose_x,
    output logic signed [ddo_pkg::POS_W-1:0]     o_pose_y,
    output logic [ddo_pkg::ANGLE_W-1:0]          o_pose_heading,
    output logic                                 o_pose_updated
);
    import ddo_pkg::*;

    localparam int SUM_W = INC_W + 1;
    localparam logic signed [PROD_W-1:0] DIST_HALF = PROD_W'(1) << (DIST_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] DIST_LIM  = PROD_W'(1) << 32;
    localparam logic signed [PROD_W-1:0] TRIG_HALF = PROD_W'(1) << (TRIG_FRAC - 1);
    localparam logic signed [POS_W-1:0]  POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_TURN,
        ST_TRIG,
        ST_MULX,
        ST_MULY,
        ST_SUM,
        ST_FINISH
    } t_state;

    function automatic logic signed [POS_W-1:0] sat_add(
        input logic signed [POS_W-1:0] p,
        input logic signed [INC_W-1:0] d
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(d);
        if (s > SUM_W'(POS_MAX)) begin
            return POS_MAX;
        end else if (s < SUM_W'(POS_MIN)) begin
            return POS_MIN;
        end
        return POS_W'(s);
    endfunction

    t_state r_state;

    // configuration
    logic [DPT_W-1:0] r_dpt;
    logic [APT_W-1:0] r_apt;

    // pose state
    logic                      r_first;
    logic [COUNT_W-1:0]        r_last_left;
    logic [COUNT_W-1:0]        r_last_right;
    logic signed [POS_W-1:0]   r_pos_x;
    logic signed [POS_W-1:0]   r_pos_y;
    logic [ANGLE_W-1:0]        r_heading;

    // working registers
    logic                      r_upd;
    logic signed [COUNT_W:0]   r_diff;
    logic signed [DIST_W-1:0]  r_dist;
    logic [ANGLE_W-1:0]        r_turn;
    logic signed [CV_W-1:0]    r_sin;
    logic signed [INC_W-1:0]   r_inc_x;
    logic signed [INC_W-1:0]   r_inc_y;

    // multiplier and cordic drive
    logic                      r_mul_start;
    logic signed [MUL_W-1:0]   r_mul_a;
    logic signed [MUL_W-1:0]   r_mul_b;
    logic                      r_cord_start;
    logic [ANGLE_W-1:0]        r_cord_angle;

    // output register
    logic                      r_out_valid;
    logic signed [POS_W-1:0]   r_out_x;
    logic signed [POS_W-1:0]   r_out_y;
    logic [ANGLE_W-1:0]        r_out_heading;
    logic                      r_out_upd;

    logic                      mul_done;
    logic signed [PROD_W-1:0]  mul_prod;
    logic                      cord_valid;
    logic signed [CV_W-1:0]    cord_cos;
    logic signed [CV_W-1:0]    cord_sin;

    logic                      in_beat;
    logic                      mul_kick;
    logic                      out_load;
    logic [COUNT_W-1:0]        dl;
    logic [COUNT_W-1:0]        dr;
    logic signed [COUNT_W:0]   sum_c;
    logic signed [COUNT_W:0]   diff_c;
    logic signed [PROD_W-1:0]  dist_rnd;
    logic signed [PROD_W-1:0]  dist_clamped;
    logic signed [PROD_W-1:0]  inc_full;

    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    ddo_cordic_chain u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cord_start),
        .i_angle (r_cord_angle),
        .o_valid (cord_valid),
        .o_cos   (cord_cos),
        .o_sin   (cord_sin)
    );

    assign o_count_ready = (r_state == ST_IDLE);
    assign in_beat       = i_count_valid && o_count_ready;

    // multiplier launched on an updating beat, after dist, cordic and x steps
    assign mul_kick = (in_beat && !r_first)
                   || (r_state == ST_DIST && mul_done)
                   || (r_state == ST_TRIG && cord_valid)
                   || (r_state == ST_MULX && mul_done);
    assign out_load = (r_state == ST_FINISH) && (!r_out_valid || i_pose_ready);

    always_comb begin
        // modular count differences, then widened sum and difference
        dl     = COUNT_W'(i_left_count) - r_last_left;
        dr     = COUNT_W'(i_right_count) - r_last_right;
        sum_c  = $signed({dl[COUNT_W-1], dl}) + $signed({dr[COUNT_W-1], dr});
        diff_c = $signed({dr[COUNT_W-1], dr}) - $signed({dl[COUNT_W-1], dl});

        dist_rnd = (mul_prod + DIST_HALF) >>> DIST_SHIFT;
        if (dist_rnd > DIST_LIM) begin
            dist_clamped = DIST_LIM;
        end else if (dist_rnd < -DIST_LIM) begin
            dist_clamped = -DIST_LIM;
        end else begin
            dist_clamped = dist_rnd;
        end

        inc_full = (mul_prod + TRIG_HALF) >>> TRIG_FRAC;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpt <= DPT_RESET;
            r_apt <= APT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIST_PER_TICK:  r_dpt <= i_cfg_data[DPT_W-1:0];
                CFG_ANGLE_PER_TICK: r_apt <= i_cfg_data[APT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_first      <= 1'b1;
            r_last_left  <= '0;
            r_last_right <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_heading    <= '0;
            r_mul_start  <= 1'b0;
            r_cord_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mul_start  <= mul_kick;
            r_cord_start <= (r_state == ST_TURN) && mul_done;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pose_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_last_left  <= COUNT_W'(i_left_count);
                        r_last_right <= COUNT_W'(i_right_count);
                        if (r_first) begin
                            // first beat only latches the counts
                            r_first <= 1'b0;
                            r_upd   <= 1'b0;
                            r_state <= ST_FINISH;
                        end else begin
                            r_upd       <= 1'b1;
                            r_diff      <= diff_c;
                            r_mul_a     <= MUL_W'(sum_c);
                            r_mul_b     <= $signed(MUL_W'(r_dpt));
                            r_state     <= ST_DIST;
                        end
                    end
                end
                ST_DIST: begin
                    if (mul_done) begin
                        r_dist      <= DIST_W'(dist_clamped);
                        r_mul_a     <= MUL_W'(r_diff);
                        r_mul_b     <= $signed(MUL_W'(r_apt));
                        r_state     <= ST_TURN;
                    end
                end
                ST_TURN: begin
                    if (mul_done) begin
                        // midpoint heading uses half the turn
                        r_turn       <= mul_prod[ANGLE_W-1:0];
                        r_cord_angle <= r_heading + mul_prod[ANGLE_W:1];
                        r_state      <= ST_TRIG;
                    end
                end
                ST_TRIG: begin
                    if (cord_valid) begin
                        r_sin       <= cord_sin;
                        r_mul_a     <= MUL_W'(r_dist);
                        r_mul_b     <= MUL_W'(cord_cos);
                        r_state     <= ST_MULX;
                    end
                end
                ST_MULX: begin
                    if (mul_done) begin
                        r_inc_x     <= INC_W'(inc_full);
                        r_mul_b     <= MUL_W'(r_sin);
                        r_state     <= ST_MULY;
                    end
                end
                ST_MULY: begin
                    if (mul_done) begin
                        r_inc_y <= INC_W'(inc_full);
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_pos_x   <= sat_add(r_pos_x, r_inc_x);
                    r_pos_y   <= sat_add(r_pos_y, r_inc_y);
                    r_heading <= r_heading + r_turn;
                    r_state   <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_load) begin
                        r_out_x       <= r_pos_x;
                        r_out_y       <= r_pos_y;
                        r_out_heading <= r_heading;
                        r_out_upd     <= r_upd;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_pose_valid   = r_out_valid;
    assign o_pose_x       = r_out_x;
    assign o_pose_y       = r_out_y;
    assign o_pose_heading = r_out_heading;
    assign o_pose_updated = r_out_upd;

endmodule
